FILE: design/triaxial_iir_filter_defines.svh
// Assertion macros used by the filter top module.
`ifndef TRIAXIAL_IIR_FILTER_DEFINES_SVH
`define TRIAXIAL_IIR_FILTER_DEFINES_SVH

// Antecedent true implies consequent in the same cycle.
`define TIAF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("filter assertion failed");

// Antecedent true implies consequent in the next cycle.
`define TIAF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("filter assertion failed");

`endif

FILE: design/tiaf_pkg.sv
package tiaf_pkg;

    localparam int FIELD_W      = 16;
    localparam int COEF_W       = 16;
    localparam int NUM_AXES     = 3;
    localparam int CFG_INDEX_W  = 3;

    localparam int DEF_FILTER_ORDER   = 2;
    localparam int DEF_SAMPLE_BITS    = 16;
    localparam int DEF_COEF_FRAC_BITS = 12;

    localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

endpackage

FILE: design/tiaf_coef_regs.sv
module tiaf_coef_regs
    import tiaf_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [COEF_W-1:0]      wr_data,
    output coef_set_t              coefs
);

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    always_comb begin
        coefs_next = coefs_reg;
        if (wr_en) begin
            unique case (reg_index_t'(wr_index))
                REG_B0:  coefs_next.b0 = $signed(wr_data);
                REG_B1:  coefs_next.b1 = $signed(wr_data);
                REG_B2:  coefs_next.b2 = $signed(wr_data);
                REG_A1:  coefs_next.a1 = $signed(wr_data);
                REG_A2:  coefs_next.a2 = $signed(wr_data);
                default: coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.b0 <= COEF_W'(1 << COEF_FRAC_BITS);
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

FILE: design/tiaf_axis.sv
module tiaf_axis
    import tiaf_pkg::*;
#(
    parameter int FILTER_ORDER   = DEF_FILTER_ORDER,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  coef_set_t                     coefs,
    input  logic signed [SAMPLE_BITS-1:0] x,
    output logic signed [SAMPLE_BITS-1:0] y
);

    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [PROD_W-1:0]      p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_W-1:0]       acc, rounded, shifted;

    assign p_b0 = coefs.b0 * x;
    assign p_b1 = coefs.b1 * x1_reg;
    assign p_b2 = coefs.b2 * x2_reg;
    assign p_a1 = coefs.a1 * y1_reg;
    assign p_a2 = coefs.a2 * y2_reg;

    always_comb begin
        acc = ACC_W'(p_b0) + ACC_W'(p_b1) - ACC_W'(p_a1);
        if (FILTER_ORDER >= 2) begin
            acc = acc + ACC_W'(p_b2) - ACC_W'(p_a2);
        end
        rounded = acc + ROUND_HALF;
        shifted = rounded >>> COEF_FRAC_BITS;
        priority if (shifted > ACC_MAX) begin
            y = Y_MAX;
        end else if (shifted < ACC_MIN) begin
            y = Y_MIN;
        end else begin
            y = SAMPLE_BITS'(shifted);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (step) begin
            x1_reg <= x;
            x2_reg <= x1_reg;
            y1_reg <= y;
            y2_reg <= y1_reg;
        end
    end

endmodule

FILE: design/triaxial_iir_filter.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata[47:0] = sample_x, sample_y, sample_z
// m_axis    out        tdata[47:0] = filtered_x, filtered_y, filtered_z
// cfg       in         cfg_index selects coef_b0..coef_a2, cfg_data is the value
//
// Each beat waits in the input register until the result register is free or being read,
// then moves into it; one beat is taken every cycle while m_tready stays high. The rate
// is set by the combinational five-tap sum (three taps when FILTER_ORDER is below 2).
// A stalled result stops the input side only once the input register is full.
// Synchronous active-low reset clears all histories and loads b0 with unity.
`include "triaxial_iir_filter_defines.svh"

module triaxial_iir_filter
    import tiaf_pkg::*;
#(
    parameter int FILTER_ORDER   = DEF_FILTER_ORDER,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // sample_x [15:0], sample_y [31:16], sample_z [47:32]
    input  logic [NUM_AXES*FIELD_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // filtered_x [15:0], filtered_y [31:16], filtered_z [47:32]
    output logic [NUM_AXES*FIELD_W-1:0] m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]          cfg_data
);

    coef_set_t coefs;

    logic                        in_valid_reg;
    logic [NUM_AXES*FIELD_W-1:0] in_data_reg;
    logic                        out_valid_reg;
    logic [NUM_AXES*FIELD_W-1:0] out_data_reg;
    logic [NUM_AXES*FIELD_W-1:0] out_data_next;
    logic                        advance;

    assign cfg_ready = 1'b1;

    tiaf_coef_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coefs    (coefs)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        logic [FIELD_W-1:0]            field;
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] y;

        assign field = in_data_reg[a*FIELD_W +: FIELD_W];
        assign x     = $signed(SAMPLE_BITS'(field));

        tiaf_axis #(
            .FILTER_ORDER   (FILTER_ORDER),
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_axis (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (advance),
            .coefs   (coefs),
            .x       (x),
            .y       (y)
        );

        assign out_data_next[a*FIELD_W +: FIELD_W] = FIELD_W'(y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `TIAF_ASSERT_SAME(a_ready_when_out_free, aclk, aresetn, !out_valid_reg, s_tready)
    `TIAF_ASSERT_NEXT(a_advance_gives_result, aclk, aresetn, advance, m_tvalid)
    `TIAF_ASSERT_SAME(a_full_stall_blocks_input, aclk, aresetn,
                      in_valid_reg && out_valid_reg && !m_tready, !s_tready)

endmodule

FILE: tb/tb_triaxial_iir_filter.sv
module tb_triaxial_iir_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import tiaf_pkg::*;

    localparam int CYCLE_LIMIT = 800000;

    class iir_scoreboard;
        logic signed [COEF_W-1:0]  coef [5];
        logic signed [FIELD_W-1:0] x_hist [NUM_AXES][2];
        logic signed [FIELD_W-1:0] y_hist [NUM_AXES][2];
        logic [NUM_AXES*FIELD_W-1:0] expected_filtered [$];
        int unsigned errors;

        function new();
            coef[REG_B0] = B0_RESET;
            coef[REG_B1] = '0;
            coef[REG_B2] = '0;
            coef[REG_A1] = '0;
            coef[REG_A2] = '0;
            for (int a = 0; a < NUM_AXES; a++) begin
                x_hist[a] = '{default: '0};
                y_hist[a] = '{default: '0};
            end
            errors = 0;
        endfunction

        function void set_coef(reg_index_t idx, logic signed [COEF_W-1:0] value);
            coef[idx] = value;
        endfunction

        function logic signed [FIELD_W-1:0] filter_axis(int axis,
                                                        logic signed [FIELD_W-1:0] x);
            longint acc;
            longint y;
            acc = longint'(coef[REG_B0]) * longint'(x)
                + longint'(coef[REG_B1]) * longint'(x_hist[axis][0])
                - longint'(coef[REG_A1]) * longint'(y_hist[axis][0]);
            if (DEF_FILTER_ORDER >= 2) begin
                acc += longint'(coef[REG_B2]) * longint'(x_hist[axis][1])
                     - longint'(coef[REG_A2]) * longint'(y_hist[axis][1]);
            end
            acc += longint'(1) << (DEF_COEF_FRAC_BITS - 1);
            y = acc >>> DEF_COEF_FRAC_BITS;
            if (y > 32767) begin
                y = 32767;
            end
            if (y < -32768) begin
                y = -32768;
            end
            x_hist[axis][1] = x_hist[axis][0];
            x_hist[axis][0] = x;
            y_hist[axis][1] = y_hist[axis][0];
            y_hist[axis][0] = FIELD_W'(y);
            return FIELD_W'(y);
        endfunction

        function void note_sample(logic [NUM_AXES*FIELD_W-1:0] beat);
            logic [NUM_AXES*FIELD_W-1:0] filtered;
            for (int a = 0; a < NUM_AXES; a++) begin
                filtered[a*FIELD_W +: FIELD_W] = filter_axis(a, beat[a*FIELD_W +: FIELD_W]);
            end
            expected_filtered.push_back(filtered);
        endfunction

        task report(string what, int got, int want);
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_filtered(logic [NUM_AXES*FIELD_W-1:0] beat);
            logic [NUM_AXES*FIELD_W-1:0] want;
            string names [NUM_AXES];
            names = '{"filtered_x", "filtered_y", "filtered_z"};
            if (expected_filtered.size() == 0) begin
                report("unexpected beat", 0, 0);
            end else begin
                want = expected_filtered.pop_front();
                for (int a = 0; a < NUM_AXES; a++) begin
                    if (beat[a*FIELD_W +: FIELD_W] !== want[a*FIELD_W +: FIELD_W]) begin
                        report(names[a], $signed(beat[a*FIELD_W +: FIELD_W]),
                               $signed(want[a*FIELD_W +: FIELD_W]));
                    end
                end
            end
        endtask
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [NUM_AXES*FIELD_W-1:0]  s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [NUM_AXES*FIELD_W-1:0]  m_tdata;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_INDEX_W-1:0]       cfg_index;
    logic [COEF_W-1:0]            cfg_data;

    iir_scoreboard sb = new();
    bit            idle_on;
    bit            pressure_req;
    int unsigned   cycle_count;
    int unsigned   hold_cycles;

    triaxial_iir_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_filtered(m_tdata);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    // The receiver decides once per cycle, so m_tready gets one update per falling edge.
    initial begin
        m_tready = 1'b0;
        hold_cycles = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (pressure_req) begin
                pressure_req = 1'b0;
                hold_cycles = 80;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                hold_cycles = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [NUM_AXES*FIELD_W-1:0] pack_axes(logic [FIELD_W-1:0] x,
                                                              logic [FIELD_W-1:0] y,
                                                              logic [FIELD_W-1:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [FIELD_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return FIELD_W'($urandom_range(0, 127) - 64);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(logic [NUM_AXES*FIELD_W-1:0] beat);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(beat);
    endtask

    task automatic finish_phase();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_filtered.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_coef(reg_index_t idx, logic [COEF_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_coef(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(int b0, int b1, int b2, int a1, int a2);
        write_coef(REG_B0, COEF_W'(b0));
        write_coef(REG_B1, COEF_W'(b1));
        write_coef(REG_B2, COEF_W'(b2));
        write_coef(REG_A1, COEF_W'(a1));
        write_coef(REG_A2, COEF_W'(a2));
    endtask

    function automatic int extreme_coef();
        case ($urandom_range(0, 3))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return 4096;
        endcase
    endfunction

    initial begin
        int a1_lim;
        int a2;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_B0;
        cfg_data = '0;
        idle_on = 1'b0;
        pressure_req = 1'b0;
        cycle_count = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Unity gain after reset passes the sample extremes straight through.
        send_sample(pack_axes(16'h7fff, 16'h8000, 16'h0000));
        send_sample(pack_axes(16'h8000, 16'h7fff, 16'hffff));
        send_sample(pack_axes(16'h0001, 16'hffff, 16'h5555));
        send_sample(pack_axes(16'h0000, 16'h0000, 16'haaaa));
        finish_phase();

        // Half gain puts odd inputs exactly on a rounding tie.
        load_coefs(2048, 0, 0, 0, 0);
        send_sample(pack_axes(16'h0001, 16'hffff, 16'h0003));
        send_sample(pack_axes(16'hfffd, 16'h7fff, 16'h8000));
        send_sample(pack_axes(16'h8001, 16'h0005, 16'hfffb));
        finish_phase();

        // Full-scale coefficients drive both bounds and feed saturated results back.
        load_coefs(32767, -32768, 32767, -32768, 32767);
        send_sample(pack_axes(16'h7fff, 16'h8000, 16'h7fff));
        send_sample(pack_axes(16'h8000, 16'h7fff, 16'h0001));
        send_sample(pack_axes(16'h7fff, 16'h7fff, 16'h8000));
        send_sample(pack_axes(16'h8000, 16'h8000, 16'hffff));
        send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));
        send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));
        finish_phase();

        load_coefs(-32768, 32767, -32768, 32767, -32768);
        send_sample(pack_axes(16'h7fff, 16'h8000, 16'h0001));
        send_sample(pack_axes(16'h8000, 16'h7fff, 16'hffff));
        send_sample(pack_axes(16'h7fff, 16'h0000, 16'h8000));
        send_sample(pack_axes(16'h0000, 16'h8000, 16'h7fff));
        send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));
        send_sample(pack_axes(16'h0000, 16'h0000, 16'h0000));
        finish_phase();

        for (int phase = 0; phase < 14; phase++) begin
            idle_on = (phase % 3 != 2);
            case (phase % 4)
                1: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
                2: load_coefs(extreme_coef(), extreme_coef(), extreme_coef(),
                              extreme_coef(), extreme_coef());
                default: begin
                    a2 = $urandom_range(0, 7000) - 3500;
                    a1_lim = 4095 + a2;
                    load_coefs($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                               $urandom_range(0, 8192) - 4096,
                               $urandom_range(0, 2 * a1_lim) - a1_lim, a2);
                end
            endcase
            for (int i = 0; i < 125; i++) begin
                if (phase == 2 && i == 5) begin
                    pressure_req = 1'b1;
                end
                send_sample(pack_axes(random_sample(), random_sample(), random_sample()));
            end
            finish_phase();
        end

        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_filtered.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
